FILE: hdl/grmr_pkg.sv
// Package for the gated running mean block.
// Holds parameter defaults, port widths and configuration register decode.
// No dependencies.
package grmr_pkg;

  // Parameter defaults
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  // Fixed field widths on the stream ports
  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned LEVEL_W       = 16;
  localparam int unsigned IN_TDATA_W    = SAMPLE_W + LEVEL_W;
  localparam int unsigned IN_TUSER_W    = 1;
  localparam int unsigned MEAN_W        = 32;
  localparam int unsigned OUT_TDATA_W   = MEAN_W;
  localparam int unsigned OUT_TUSER_W   = 2;

  // Configuration port
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  // Register index sits at paddr[2]; the low two bits are not decoded
  localparam logic        REG_USE_COND  = 1'b0;
  localparam logic        USE_COND_RST  = 1'b1;

endpackage

FILE: hdl/gated_running_mean_with_reset.sv
// Gated running mean with restart on a rising reset channel: top level.
// Accumulates gated samples and divides sum by count with a bit-serial divider.
// Depends on grmr_pkg.
//
// Each input transaction passes through the PREP, DIV and OUT states, with DIV
//   skipped when the count is zero; SUM_W = min(SAMPLE_BITS, 32) + COUNT_BITS.
// A new transaction is accepted only in the idle state, after the previous
//   result is handed on; the restoring divider retires one quotient bit per cycle.
// Reset (rst_ni low, asynchronous): sum, count, previous level and primed flag
//   clear, use_condition returns to 1, both stream sides go idle.
module gated_running_mean_with_reset #(
  parameter int unsigned SAMPLE_BITS = grmr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = grmr_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: [31:0] sample (Q16.16), [47:32] reset_level
  input  logic [grmr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser: [0] condition
  input  logic [grmr_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: [31:0] mean (Q16.16)
  output logic [grmr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // tuser: [0] empty_res, [1] restarted
  output logic [grmr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [grmr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [grmr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [grmr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import grmr_pkg::*;

  // Effective sample width and accumulator width
  localparam int unsigned SW     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int unsigned SUM_W  = SW + COUNT_BITS;
  // Quotient view wide enough to test against 2^31
  localparam int unsigned QW     = (SUM_W > 33) ? SUM_W : 33;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an input transaction
  localparam logic [1:0] ST_PREP = 2'd1;  // take magnitude of the sum
  localparam logic [1:0] ST_DIV  = 2'd2;  // one quotient bit per cycle
  localparam logic [1:0] ST_OUT  = 2'd3;  // hand result to the output register

  logic [1:0]             state_q, state_d;

  // Accumulator state
  logic                   primed_q, primed_d;
  logic signed [LEVEL_W-1:0] prev_q, prev_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic                   rose_q, rose_d;
  logic                   use_cond_q;

  // Divider datapath
  logic [SUM_W-1:0]       quo_q, quo_d;
  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   neg_q, neg_d;

  // Output register
  logic                   m_valid_q, m_valid_d;
  logic [MEAN_W-1:0]      mean_q, mean_d;
  logic                   empty_q, empty_d;
  logic                   rest_q, rest_d;

  // -------------------------------------------------------------------------
  // Configuration: single register, write on the access phase
  // -------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_USE_COND);
  assign prdata = (paddr[2] == REG_USE_COND) ? CFG_DATA_W'(use_cond_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_cond_q <= USE_COND_RST;
    end else if (cfg_wr) begin
      use_cond_q <= pwdata[0];
    end
  end

  // -------------------------------------------------------------------------
  // Input decode
  // -------------------------------------------------------------------------
  logic                      s_fire;
  logic signed [LEVEL_W-1:0] level;
  logic signed [SUM_W-1:0]   sample_ext;
  logic                      cond;
  logic                      qualifies;
  logic                      cnt_full;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign level      = s_axis_tdata_i[SAMPLE_W +: LEVEL_W];
  // Keep the low SW bits of the sample and sign extend them
  assign sample_ext = {{COUNT_BITS{s_axis_tdata_i[SW-1]}}, s_axis_tdata_i[SW-1:0]};
  assign cond       = s_axis_tuser_i[0];
  assign cnt_full   = &cnt_q;
  assign qualifies  = (!use_cond_q || cond) && !cnt_full;

  // -------------------------------------------------------------------------
  // Divider step: restoring, MSB of the dividend shifts into the remainder
  // -------------------------------------------------------------------------
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  q_bit;

  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, cnt_q};
  assign q_bit    = (rem_sh >= {1'b0, cnt_q});

  // -------------------------------------------------------------------------
  // Sign and saturation of the final quotient
  // -------------------------------------------------------------------------
  logic [QW-1:0]      q_ext;
  logic               pos_ovf;
  logic               neg_ovf;
  logic [MEAN_W-1:0]  mean_fix;

  assign q_ext   = QW'(quo_q);
  assign pos_ovf = |q_ext[QW-1:31];
  assign neg_ovf = (|q_ext[QW-1:32]) || (q_ext[31] && (|q_ext[30:0]));

  always_comb begin
    if (neg_q) begin
      mean_fix = neg_ovf ? {1'b1, {(MEAN_W-1){1'b0}}} : (~q_ext[MEAN_W-1:0] + 1'b1);
    end else begin
      mean_fix = pos_ovf ? {1'b0, {(MEAN_W-1){1'b1}}} : q_ext[MEAN_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer and accumulator
  // -------------------------------------------------------------------------
  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    primed_d  = primed_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    rose_d    = rose_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    step_d    = step_q;
    neg_d     = neg_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    mean_d    = mean_q;
    empty_d   = empty_q;
    rest_d    = rest_q;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          rose_d  = 1'b0;
          prev_d  = level;
          if (!primed_q) begin
            // First transaction only primes the previous level
            primed_d = 1'b1;
          end else if (level > prev_q) begin
            // Rising level: restart and drop this sample
            rose_d = 1'b1;
            sum_d  = '0;
            cnt_d  = '0;
          end else if (qualifies) begin
            sum_d = sum_q + sample_ext;
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Load magnitude of the sum; sum is zero whenever count is zero
        neg_d  = sum_q[SUM_W-1];
        quo_d  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_d  = '0;
        step_d = STEP_W'(SUM_W);
        state_d = (cnt_q == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        quo_d  = {quo_q[SUM_W-2:0], q_bit};
        rem_d  = q_bit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        step_d = step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register can take the result
        if (out_free) begin
          m_valid_d = 1'b1;
          empty_d   = (cnt_q == '0);
          mean_d    = (cnt_q == '0) ? '0 : mean_fix;
          rest_d    = rose_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      primed_q  <= 1'b0;
      prev_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      rose_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      primed_q  <= primed_d;
      prev_q    <= prev_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      rose_q    <= rose_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    mean_q  <= mean_d;
    empty_q <= empty_d;
    rest_q  <= rest_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = mean_q;
  assign m_axis_tuser_o  = {rest_q, empty_q};

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // Remainder stays below the divisor throughout the division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ({1'b0, rem_q} < {1'b0, cnt_q}))
    else $error("divider remainder not below divisor");

  // Count never drops except on a restart
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !(primed_q && (level > prev_q))) |=> (cnt_q >= $past(cnt_q)))
    else $error("sample count dropped without restart");

  // An empty result always carries a zero mean
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && empty_q) |-> (mean_q == '0))
    else $error("empty result with nonzero mean");

  // Sum is zero whenever the count is zero
  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with zero count");

endmodule
